// ===== sv/tlr_pkg.sv =====
// shared types and constants of the thick line rasterizer
`timescale 1ns / 1ps
`default_nettype none
package tlr_pkg;

   localparam int IMG_BITS       = 13;
   localparam int COLOR_BITS     = 32;
   localparam int STROKE_BITS    = 7;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [IMG_BITS-1:0]    IMG_DIM_RESET = 13'd1024;
   localparam logic [COLOR_BITS-1:0]  COLOR_RESET   = 32'hFF00_0000;
   localparam logic [STROKE_BITS-1:0] STROKE_MIN    = 7'd2;
   // half-width offset: wd = (q + 4) / 8 in quarter pixels
   localparam logic [STROKE_BITS:0]   STROKE_BIAS   = 8'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAW_COLOR    = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_PRESENT = 8'd3;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_MAIN  = 7'b0000010,
      PH_XCHK  = 7'b0000100,
      PH_LOOPA = 7'b0001000,
      PH_YCHK  = 7'b0010000,
      PH_LOOPB = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   typedef enum logic [5:0] {
      ST_READY = 6'b000001,
      ST_SQX   = 6'b000010,
      ST_SQY   = 6'b000100,
      ST_ROOT  = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_WALK  = 6'b100000
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic sq_x;
      logic sq_y;
      logic root_step;
      logic scale;
      logic walk;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== sv/tlr_if.sv =====
// channel interfaces: input items, result items and register writes
`timescale 1ns / 1ps
`default_nettype none
interface tlr_req_if #(parameter int COORD_BITS = 13);
   logic valid;
   logic ready;
   logic action;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [tlr_pkg::STROKE_BITS-1:0] stroke_quarters;
   modport source (output valid, action, start_x, start_y, end_x, end_y, stroke_quarters,
                   input ready);
   modport sink (input valid, action, start_x, start_y, end_x, end_y, stroke_quarters,
                 output ready);
endinterface

interface tlr_rsp_if #(parameter int COORD_BITS = 13);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic visible;
   logic [tlr_pkg::COLOR_BITS-1:0] pixel_color;
   logic write_alpha;
   logic done_res;
   modport source (output valid, pixel_x, pixel_y, visible, pixel_color, write_alpha,
                   done_res, input ready);
   modport sink (input valid, pixel_x, pixel_y, visible, pixel_color, write_alpha,
                 done_res, output ready);
endinterface

interface tlr_csr_if;
   logic valid;
   logic ready;
   logic [tlr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [tlr_pkg::CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/thick_line_rasterizer_core.sv =====
// top level of the thick line rasterizer
// A start transfer loads the endpoints and stroke and yields no result; the
// block then holds ready low while it squares dx and dy, runs the bit-pair
// square root one step per cycle, and scales the threshold.
// A step transfer walks the datapath phases, one walk step per phase and
// only while the output register is free, until a phase yields one result,
// and the next transfer is taken once the result is held in the output
// register. A step with no line loaded, or after the line ended, returns a
// result with done_res set and all else 0.
// Register writes are always accepted and take effect at once.
`timescale 1ns / 1ps
`default_nettype none
module thick_line_rasterizer_core #(
   parameter int COORD_BITS       = 13,
   parameter int THRESH_FRAC_BITS = 8
) (
   input wire logic clock,
   input wire logic reset,
   tlr_req_if.sink   req_ch,
   tlr_rsp_if.source rsp_ch,
   tlr_csr_if.sink   csr_ch
);
   tlr_pkg::dp_cmd_type    cmd;
   tlr_pkg::dp_status_type status;

   assign csr_ch.ready = 1'b1;

   tlr_ctrl #(
      .ROOT_STEPS(COORD_BITS + 1 + THRESH_FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .cmd        (cmd),
      .status     (status)
   );

   tlr_dp #(
      .COORD_BITS       (COORD_BITS),
      .THRESH_FRAC_BITS (THRESH_FRAC_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_start_x         (req_ch.start_x),
      .req_start_y         (req_ch.start_y),
      .req_end_x           (req_ch.end_x),
      .req_end_y           (req_ch.end_y),
      .req_stroke_quarters (req_ch.stroke_quarters),
      .csr_write           (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_pixel_x         (rsp_ch.pixel_x),
      .rsp_pixel_y         (rsp_ch.pixel_y),
      .rsp_visible         (rsp_ch.visible),
      .rsp_pixel_color     (rsp_ch.pixel_color),
      .rsp_write_alpha     (rsp_ch.write_alpha),
      .rsp_done_res        (rsp_ch.done_res)
   );
endmodule
`default_nettype wire

// ===== sv/tlr_ctrl.sv =====
// controller: sequences line setup, the square root and the walk steps
`timescale 1ns / 1ps
`default_nettype none
module tlr_ctrl #(
   parameter int ROOT_STEPS = 22
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_action,
   output logic                       req_ready,
   output tlr_pkg::dp_cmd_type        cmd,
   input  wire tlr_pkg::dp_status_type status
);
   localparam int CW = (ROOT_STEPS > 1) ? $clog2(ROOT_STEPS) : 1;
   localparam logic [CW-1:0] LAST = CW'(ROOT_STEPS - 1);

   tlr_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic req_xfer;

   assign req_ready = (state_ff == tlr_pkg::ST_READY);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         tlr_pkg::ST_READY: begin
            if (req_xfer) begin
               if (req_action == tlr_pkg::ACTION_START) begin
                  cmd.load = 1'b1;
                  state_in = tlr_pkg::ST_SQX;
               end else begin
                  state_in = tlr_pkg::ST_WALK;
               end
            end
         end
         tlr_pkg::ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = tlr_pkg::ST_SQY;
         end
         tlr_pkg::ST_SQY: begin
            cmd.sq_y = 1'b1;
            cnt_in   = '0;
            state_in = tlr_pkg::ST_ROOT;
         end
         tlr_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == LAST) state_in = tlr_pkg::ST_SCALE;
         end
         tlr_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = tlr_pkg::ST_READY;
         end
         tlr_pkg::ST_WALK: begin
            cmd.walk = status.out_free;
            if (status.emit) state_in = tlr_pkg::ST_READY;
         end
         default: state_in = tlr_pkg::ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlr_pkg::ST_READY;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_root_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlr_pkg::ST_ROOT && cnt_ff == LAST) |=> state_ff == tlr_pkg::ST_SCALE)
      else $error("square root did not end after its last step");
   a_start_setup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == tlr_pkg::ST_SQX)
      else $error("start transfer did not enter setup");
   a_emit_in_walk: assert property (@(posedge clock) disable iff (reset)
      status.emit |-> state_ff == tlr_pkg::ST_WALK)
      else $error("result produced outside a step");
endmodule
`default_nettype wire

// ===== sv/tlr_dp.sv =====
// datapath: line setup, shift-subtract square root, walk and result register
`timescale 1ns / 1ps
`default_nettype none
module tlr_dp #(
   parameter int COORD_BITS       = 13,
   parameter int THRESH_FRAC_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire tlr_pkg::dp_cmd_type cmd,
   output tlr_pkg::dp_status_type   status,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic [tlr_pkg::STROKE_BITS-1:0] req_stroke_quarters,
   input  wire logic csr_write,
   input  wire logic [tlr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tlr_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic rsp_visible,
   output logic [tlr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic rsp_write_alpha,
   output logic rsp_done_res
);
   localparam int C   = COORD_BITS;
   localparam int F   = THRESH_FRAC_BITS;
   localparam int PW  = C + 2;              // cursor and side coordinates
   localparam int EB  = C + 10;             // error terms
   localparam int SW  = 2 * C + 1;          // dx^2 + dy^2
   localparam int RN  = C + 1 + F;          // square root bits
   localparam int RW  = 2 * RN;             // radicand
   localparam int TB  = RN + 5;             // width threshold
   localparam int LW  = EB + F;             // threshold compare
   localparam int XW  = (PW > tlr_pkg::IMG_BITS) ? PW : tlr_pkg::IMG_BITS;
   localparam int QB  = tlr_pkg::STROKE_BITS + 1;

   // configuration
   logic [tlr_pkg::IMG_BITS-1:0]   img_w_ff, img_h_ff;
   logic [tlr_pkg::COLOR_BITS-1:0] color_ff;
   logic                           alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= tlr_pkg::IMG_DIM_RESET;
         img_h_ff <= tlr_pkg::IMG_DIM_RESET;
         color_ff <= tlr_pkg::COLOR_RESET;
         alpha_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            tlr_pkg::CSR_IMAGE_WIDTH:   img_w_ff <= csr_data[tlr_pkg::IMG_BITS-1:0];
            tlr_pkg::CSR_IMAGE_HEIGHT:  img_h_ff <= csr_data[tlr_pkg::IMG_BITS-1:0];
            tlr_pkg::CSR_DRAW_COLOR:    color_ff <= csr_data[tlr_pkg::COLOR_BITS-1:0];
            tlr_pkg::CSR_ALPHA_PRESENT: alpha_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // line state
   logic signed [PW-1:0] cx_ff, cy_ff, tx_ff, ty_ff, x2_ff, y2_ff;
   logic signed [PW-1:0] cx_in, cy_in, x2_in, y2_in;
   logic [C-1:0]         dx_ff, dy_ff;
   logic                 nx_ff, ny_ff, zero_ff;
   logic signed [EB-1:0] err_ff, e2_ff, err_in, e2_in;
   logic [tlr_pkg::STROKE_BITS-1:0] q_ff;
   logic [TB-1:0]        thr_ff;
   tlr_pkg::phase_type   ph_ff, ph_in;

   // setup and root state
   logic [SW-1:0]   acc_ff;
   logic [RW-1:0]   rad_ff;
   logic [RN+1:0]   rem_ff;
   logic [RN-1:0]   root_ff;

   // result register
   logic                         out_v_ff;
   logic signed [C-1:0]          out_x_ff, out_y_ff;
   logic                         out_vis_ff, out_alpha_ff, out_done_ff;
   logic [tlr_pkg::COLOR_BITS-1:0] out_color_ff;

   // setup terms from the start transfer
   logic signed [PW-1:0] lx0, ly0, lx1, ly1, ldx, ldy;
   assign lx0 = PW'(req_start_x);
   assign ly0 = PW'(req_start_y);
   assign lx1 = PW'(req_end_x);
   assign ly1 = PW'(req_end_y);
   assign ldx = (lx1 > lx0) ? lx1 - lx0 : lx0 - lx1;
   assign ldy = (ly1 > ly0) ? ly1 - ly0 : ly0 - ly1;

   // square root step
   logic [RN+1:0] rem_sh, trial;
   assign rem_sh = {rem_ff[RN-1:0], rad_ff[RW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   // threshold scaling
   logic [RN-1:0]   ed;
   logic [QB-1:0]   qb;
   logic [RN+QB-1:0] prod;
   assign ed   = zero_ff ? RN'(1 << F) : root_ff;
   assign qb   = {1'b0, q_ff} + tlr_pkg::STROKE_BIAS;
   assign prod = ed * qb;

   // walk terms
   logic signed [EB-1:0] dxe, dye;
   logic signed [PW-1:0] sx, sy, nsx, nsy;
   logic signed [LW-1:0] lhs, rhs;
   logic below;
   assign dxe   = $signed({{(EB-C){1'b0}}, dx_ff});
   assign dye   = $signed({{(EB-C){1'b0}}, dy_ff});
   assign sx    = {{(PW-1){nx_ff}}, 1'b1};
   assign sy    = {{(PW-1){ny_ff}}, 1'b1};
   assign nsx   = x2_ff + sx;
   assign nsy   = y2_ff + sy;
   assign lhs   = {e2_ff, {F{1'b0}}};
   assign rhs   = $signed({{(LW-TB){1'b0}}, thr_ff});
   assign below = lhs < rhs;

   function automatic logic inside_dim(input logic signed [PW-1:0] p,
                                       input logic [tlr_pkg::IMG_BITS-1:0] lim);
      return !p[PW-1] && (XW'(p[PW-2:0]) < XW'(lim));
   endfunction

   logic emit, emit_done;
   logic signed [PW-1:0] ex, ey;
   logic out_free;
   assign out_free = !out_v_ff || rsp_ready;

   always_comb begin
      emit      = 1'b0;
      emit_done = 1'b0;
      ex        = cx_ff;
      ey        = cy_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x2_in     = x2_ff;
      y2_in     = y2_ff;
      err_in    = err_ff;
      e2_in     = e2_ff;
      ph_in     = ph_ff;
      unique case (ph_ff)
         tlr_pkg::PH_MAIN: begin
            emit  = 1'b1;
            e2_in = err_ff;
            x2_in = cx_ff;
            ph_in = tlr_pkg::PH_XCHK;
         end
         tlr_pkg::PH_XCHK: begin
            if ((e2_ff <<< 1) >= -dxe) begin
               e2_in = e2_ff + dye;
               y2_in = cy_ff;
               ph_in = tlr_pkg::PH_LOOPA;
            end else begin
               ph_in = tlr_pkg::PH_YCHK;
            end
         end
         tlr_pkg::PH_LOOPA: begin
            if (below && (ty_ff != y2_ff || dx_ff > dy_ff)) begin
               y2_in = nsy;
               emit  = 1'b1;
               ey    = nsy;
               e2_in = e2_ff + dxe;
            end else if (cx_ff == tx_ff) begin
               ph_in     = tlr_pkg::PH_DONE;
               emit      = 1'b1;
               emit_done = 1'b1;
            end else begin
               e2_in  = err_ff;
               err_in = err_ff - dye;
               cx_in  = cx_ff + sx;
               ph_in  = tlr_pkg::PH_YCHK;
            end
         end
         tlr_pkg::PH_YCHK: begin
            if ((e2_ff <<< 1) <= dye) begin
               e2_in = dxe - e2_ff;
               ph_in = tlr_pkg::PH_LOOPB;
            end else begin
               ph_in = tlr_pkg::PH_MAIN;
            end
         end
         tlr_pkg::PH_LOOPB: begin
            if (below && (tx_ff != x2_ff || dx_ff < dy_ff)) begin
               x2_in = nsx;
               emit  = 1'b1;
               ex    = nsx;
               e2_in = e2_ff + dye;
            end else if (cy_ff == ty_ff) begin
               ph_in     = tlr_pkg::PH_DONE;
               emit      = 1'b1;
               emit_done = 1'b1;
            end else begin
               err_in = err_ff + dxe;
               cy_in  = cy_ff + sy;
               ph_in  = tlr_pkg::PH_MAIN;
            end
         end
         default: begin
            emit      = 1'b1;
            emit_done = 1'b1;
         end
      endcase
   end

   assign status.emit     = cmd.walk && emit;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= tlr_pkg::PH_IDLE;
      end else if (cmd.load) begin
         ph_ff <= tlr_pkg::PH_MAIN;
      end else if (cmd.walk) begin
         ph_ff <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff   <= lx0;
         cy_ff   <= ly0;
         tx_ff   <= lx1;
         ty_ff   <= ly1;
         dx_ff   <= ldx[C-1:0];
         dy_ff   <= ldy[C-1:0];
         nx_ff   <= !(lx0 < lx1);
         ny_ff   <= !(ly0 < ly1);
         err_ff  <= EB'(ldx) - EB'(ldy);
         e2_ff   <= '0;
         x2_ff   <= '0;
         y2_ff   <= '0;
         zero_ff <= (ldx == '0) && (ldy == '0);
         q_ff    <= (req_stroke_quarters < tlr_pkg::STROKE_MIN) ? tlr_pkg::STROKE_MIN
                                                                 : req_stroke_quarters;
      end else if (cmd.walk) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         x2_ff  <= x2_in;
         y2_ff  <= y2_in;
         err_ff <= err_in;
         e2_ff  <= e2_in;
      end
      if (cmd.sq_x) acc_ff <= SW'(dx_ff) * SW'(dx_ff);
      if (cmd.sq_y) begin
         rad_ff  <= {{(RW-SW-2*F){1'b0}}, acc_ff + SW'(dy_ff) * SW'(dy_ff), {(2*F){1'b0}}};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[RW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RN-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RN-2:0], 1'b0};
         end
      end
      if (reset) thr_ff <= '0;
      else if (cmd.scale) thr_ff <= prod[RN+QB-1:3];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (status.emit) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
      if (status.emit) begin
         out_done_ff  <= emit_done;
         out_x_ff     <= emit_done ? '0 : ex[C-1:0];
         out_y_ff     <= emit_done ? '0 : ey[C-1:0];
         out_vis_ff   <= !emit_done && inside_dim(ex, img_w_ff) && inside_dim(ey, img_h_ff);
         out_color_ff <= emit_done ? '0 : color_ff;
         out_alpha_ff <= !emit_done && alpha_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_visible     = out_vis_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_write_alpha = out_alpha_ff;
   assign rsp_done_res    = out_done_ff;

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      status.emit |=> out_v_ff)
      else $error("produced result not held in output register");
   a_thr_set: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |=> thr_ff != '0)
      else $error("width threshold is zero after setup");
   a_walk_room: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> out_free)
      else $error("walk step with output register occupied");
endmodule
`default_nettype wire

// ===== sim/thick_line_rasterizer_core_tb.sv =====
// self-checking testbench of the thick line rasterizer: random and directed lines
`timescale 1ns / 1ps
`default_nettype none
module thick_line_rasterizer_core_tb;

   localparam int CB = 13;
   localparam int FB = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic action;
      logic signed [CB-1:0] sx, sy, ex, ey;
      logic [tlr_pkg::STROKE_BITS-1:0] stroke;
   } line_cmd_type;

   typedef struct packed {
      logic [CB-1:0] px, py;
      logic vis;
      logic [31:0] color;
      logic alpha;
      logic done;
   } pixel_type;

   typedef enum int {W_IDLE, W_MAIN, W_XCHK, W_LOOPA, W_YCHK, W_LOOPB, W_DONE} walk_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlr_req_if #(CB) req_ch ();
   tlr_rsp_if #(CB) rsp_ch ();
   tlr_csr_if csr_ch ();

   thick_line_rasterizer_core #(.COORD_BITS(CB), .THRESH_FRAC_BITS(FB)) uut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   // predictor state
   longint cur_x, cur_y, tgt_x, tgt_y, span_dx, span_dy, side_px, side_py;
   longint err_acc, trial;
   bit neg_x, neg_y;
   longint thresh;
   walk_type phase = W_IDLE;
   longint img_w = 1024, img_h = 1024;
   logic [31:0] pen = tlr_pkg::COLOR_RESET;
   logic pen_alpha = 1'b0;

   line_cmd_type pending_cmds[$];
   pixel_type expected_pixels[$];
   int errors = 0, n_pixels = 0, n_lines = 0, n_done = 0;
   int idle_pct = 22;
   int stall_cycles = 0;
   bit stim_done = 1'b0;
   bit req_taken = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0; b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b); r = (r >>> 1) + b;
         end else r = r >>> 1;
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic pixel_type make_pixel(longint x, longint y);
      pixel_type p;
      p.px = x[CB-1:0]; p.py = y[CB-1:0];
      p.vis = (x >= 0 && x < img_w && y >= 0 && y < img_h);
      p.color = pen; p.alpha = pen_alpha; p.done = 1'b0;
      return p;
   endfunction

   function automatic pixel_type done_pixel();
      pixel_type p;
      p = '0; p.done = 1'b1;
      return p;
   endfunction

   // advance the walk model for one accepted transfer
   task automatic predict_line(input line_cmd_type c);
      longint ed, q, stx, sty;
      pixel_type p;
      if (c.action == tlr_pkg::ACTION_START) begin
         cur_x = c.sx; cur_y = c.sy; tgt_x = c.ex; tgt_y = c.ey;
         span_dx = tgt_x > cur_x ? tgt_x - cur_x : cur_x - tgt_x;
         span_dy = tgt_y > cur_y ? tgt_y - cur_y : cur_y - tgt_y;
         neg_x = !(cur_x < tgt_x); neg_y = !(cur_y < tgt_y);
         err_acc = span_dx - span_dy; trial = 0; side_px = 0; side_py = 0;
         q = c.stroke < tlr_pkg::STROKE_MIN ? tlr_pkg::STROKE_MIN : c.stroke;
         if (span_dx + span_dy == 0) ed = 64'sd1 << FB;
         else ed = int_sqrt((span_dx * span_dx + span_dy * span_dy) << (2 * FB));
         thresh = (ed * (q + 4)) >>> 3;
         phase = W_MAIN;
         n_lines++;
         return;
      end
      stx = neg_x ? -1 : 1; sty = neg_y ? -1 : 1;
      forever begin
         case (phase)
            W_MAIN: begin
               p = make_pixel(cur_x, cur_y);
               trial = err_acc; side_px = cur_x; phase = W_XCHK;
               break;
            end
            W_XCHK: begin
               if (2 * trial >= -span_dx) begin
                  trial += span_dy; side_py = cur_y; phase = W_LOOPA;
               end else phase = W_YCHK;
            end
            W_LOOPA: begin
               if ((trial <<< FB) < thresh && (tgt_y != side_py || span_dx > span_dy)) begin
                  side_py += sty; p = make_pixel(cur_x, side_py); trial += span_dx;
                  break;
               end
               if (cur_x == tgt_x) begin
                  phase = W_DONE; p = done_pixel(); break;
               end
               trial = err_acc; err_acc -= span_dy; cur_x += stx; phase = W_YCHK;
            end
            W_YCHK: begin
               if (2 * trial <= span_dy) begin
                  trial = span_dx - trial; phase = W_LOOPB;
               end else phase = W_MAIN;
            end
            W_LOOPB: begin
               if ((trial <<< FB) < thresh && (tgt_x != side_px || span_dx < span_dy)) begin
                  side_px += stx; p = make_pixel(side_px, cur_y); trial += span_dy;
                  break;
               end
               if (cur_y == tgt_y) begin
                  phase = W_DONE; p = done_pixel(); break;
               end
               err_acc += span_dx; cur_y += sty; phase = W_MAIN;
            end
            default: begin
               p = done_pixel(); break;
            end
         endcase
      end
      expected_pixels.push_back(p);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h (pixel %0d)", what, got, want, n_pixels);
   endtask

   // driver
   initial begin
      req_ch.valid = 1'b0; req_ch.action = tlr_pkg::ACTION_STEP;
      req_ch.start_x = '0; req_ch.start_y = '0; req_ch.end_x = '0; req_ch.end_y = '0;
      req_ch.stroke_quarters = '0;
   end

   // input transfers are seen at the rising edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_line(pending_cmds.pop_front());
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_ch.valid || req_taken) begin
            req_taken = 1'b0;
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.action <= pending_cmds[0].action;
               req_ch.start_x <= pending_cmds[0].sx;
               req_ch.start_y <= pending_cmds[0].sy;
               req_ch.end_x <= pending_cmds[0].ex;
               req_ch.end_y <= pending_cmds[0].ey;
               req_ch.stroke_quarters <= pending_cmds[0].stroke;
            end else req_ch.valid <= 1'b0;
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_pixels++;
         if (rsp_ch.done_res) n_done++;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", '0, '0);
         end else begin
            w = expected_pixels.pop_front();
            if (rsp_ch.pixel_x !== w.px) report_mismatch("pixel_x", rsp_ch.pixel_x, w.px);
            if (rsp_ch.pixel_y !== w.py) report_mismatch("pixel_y", rsp_ch.pixel_y, w.py);
            if (rsp_ch.visible !== w.vis) report_mismatch("visible", rsp_ch.visible, w.vis);
            if (rsp_ch.pixel_color !== w.color)
               report_mismatch("pixel_color", rsp_ch.pixel_color, w.color);
            if (rsp_ch.write_alpha !== w.alpha)
               report_mismatch("write_alpha", rsp_ch.write_alpha, w.alpha);
            if (rsp_ch.done_res !== w.done) report_mismatch("done_res", rsp_ch.done_res, w.done);
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         stall_cycles <= 0;
      else if (!stim_done || expected_pixels.size() > 0) begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_pixels.size());
            $display("FAIL thick_line_rasterizer_core");
            $finish;
         end
      end
   end

   task automatic push_start(input int x0, input int y0, input int x1, input int y1,
                             input int q);
      line_cmd_type c;
      c.action = tlr_pkg::ACTION_START;
      c.sx = x0[CB-1:0]; c.sy = y0[CB-1:0]; c.ex = x1[CB-1:0]; c.ey = y1[CB-1:0];
      c.stroke = q[tlr_pkg::STROKE_BITS-1:0];
      pending_cmds.push_back(c);
   endtask

   task automatic push_steps(input int n);
      line_cmd_type c;
      logic [31:0] r;
      c = '0; c.action = tlr_pkg::ACTION_STEP;
      c.sx = CB'($urandom); c.sy = CB'($urandom);
      c.ex = CB'($urandom); c.ey = CB'($urandom);
      r = $urandom;
      c.stroke = r[tlr_pkg::STROKE_BITS-1:0];
      repeat (n) pending_cmds.push_back(c);
   endtask

   task automatic drain();
      wait (pending_cmds.size() == 0 && !req_ch.valid);
      wait (expected_pixels.size() == 0);
      // a start may still be running its square root
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tlr_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [31:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.data <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         tlr_pkg::CSR_IMAGE_WIDTH: img_w = v[12:0];
         tlr_pkg::CSR_IMAGE_HEIGHT: img_h = v[12:0];
         tlr_pkg::CSR_DRAW_COLOR: pen = v;
         tlr_pkg::CSR_ALPHA_PRESENT: pen_alpha = v[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic int rand_coord(input int near);
      if ($urandom_range(9) == 0) return $signed($urandom_range(8191) - 4096);
      return near + $signed($urandom_range(40)) - 20;
   endfunction

   initial begin
      int x0, y0, len;
      csr_ch.valid = 1'b0; csr_ch.index = '0; csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: step while idle, point, extremes, restart mid line
      push_steps(2);
      push_start(5, 5, 5, 5, 0);  push_steps(12);
      push_start(-4096, 4095, 4095, -4096, 1); push_steps(3);
      push_start(0, 0, 7, 3, 127); push_steps(2);
      push_start(1023, 1020, 1030, 1023, 9); push_steps(40);
      push_start(3, -2, -1, 6, 20); push_steps(60);
      drain();

      // pause the sender until empty, then configure extremes
      write_reg(tlr_pkg::CSR_IMAGE_WIDTH, 1); write_reg(tlr_pkg::CSR_IMAGE_HEIGHT, 4096);
      write_reg(tlr_pkg::CSR_DRAW_COLOR, 32'hFFFF_FFFF);
      write_reg(tlr_pkg::CSR_ALPHA_PRESENT, 1);
      write_reg(8'd200, 32'h1234);
      push_start(0, 2, 0, -2, 4); push_steps(30);
      push_start(4094, 4090, 4095, 4095, 127); push_steps(200);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(tlr_pkg::CSR_IMAGE_WIDTH, ph == 3 ? 4096 : $urandom_range(4096, 1));
         write_reg(tlr_pkg::CSR_IMAGE_HEIGHT, ph == 0 ? 1 : $urandom_range(4096, 1));
         write_reg(tlr_pkg::CSR_DRAW_COLOR, ph == 1 ? 32'h0 : $urandom);
         write_reg(tlr_pkg::CSR_ALPHA_PRESENT, ph[0]);
         idle_pct = (ph == 2) ? 0 : 22;
         for (int k = 0; k < 18; k++) begin
            x0 = $urandom_range(8191) - 4096; y0 = $urandom_range(8191) - 4096;
            if ($urandom_range(3) != 0) begin
               x0 = $urandom_range(60) - 10; y0 = $urandom_range(60) - 10;
            end
            push_start(x0, y0, rand_coord(x0), rand_coord(y0),
                       $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(12));
            len = $urandom_range(3) == 0 ? $urandom_range(8) : $urandom_range(40);
            push_steps(len);
         end
         drain();
      end
      stim_done = 1'b1;
      repeat (50) @(posedge clock);
      $display("ran %0d lines, %0d result transfers (%0d done markers)",
               n_lines, n_pixels, n_done);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("PASS thick_line_rasterizer_core");
      end else begin
         $display("FAIL thick_line_rasterizer_core");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/tlr_pkg.sv
sv/tlr_if.sv
sv/tlr_ctrl.sv
sv/tlr_dp.sv
sv/thick_line_rasterizer_core.sv
sim/thick_line_rasterizer_core_tb.sv
